// ===== sv/dfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfmd_pkg
// Shared constants, register map and stage types of the depth frame motion
// detector.
// ----------------------------------------------------------------------------
package dfmd_pkg;

  localparam int FRAME_PIXELS = 307200;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int IDX_W        = $clog2(FRAME_PIXELS + 1);
  localparam int CNT_W        = IDX_W;
  localparam int OUT_CNT_W    = 19;
  localparam int DEPTH_W      = 16;
  localparam int RATE_W       = 16;
  localparam int HOLD_W       = 32;
  localparam int PROD_W       = RATE_W + CNT_W;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [1:0] REG_DEPTH_THR = 2'd0;
  localparam logic [1:0] REG_RATE_THR  = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;

  localparam logic [DEPTH_W-1:0] DEPTH_THR_RESET = 16'd200;
  localparam logic [RATE_W-1:0]  RATE_THR_RESET  = 16'd655;
  localparam logic [HOLD_W-1:0]  HOLD_RESET      = 32'd5000;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_threshold;
    logic [RATE_W-1:0]  rate_threshold;
    logic [HOLD_W-1:0]  hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               tick;
    logic               eof;
    logic               is_ref;
    logic               cmp_en;
    logic [DEPTH_W-1:0] depth;
  } pix_stage_t;

  typedef struct packed {
    logic             valid;
    logic             tick;
    logic             eof;
    logic             is_ref;
    logic [CNT_W-1:0] vcnt;
    logic [CNT_W-1:0] mcnt;
  } frame_stage_t;

endpackage

// ===== sv/dfmd_if.sv =====
// ----------------------------------------------------------------------------
// dfmd_if
// Valid/ready channels for depth samples and frame decisions.
// ----------------------------------------------------------------------------
interface dfmd_in_if import dfmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DEPTH_W-1:0] depth_mm;
  logic               end_of_frame;

  modport source (output valid, output mode, output depth_mm, output end_of_frame,
                  input ready);
  modport sink (input valid, input mode, input depth_mm, input end_of_frame,
                output ready);
endinterface

interface dfmd_out_if import dfmd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 save_frame;
  logic                 became_reference;
  logic                 motion_found;
  logic [OUT_CNT_W-1:0] moved_pixels;
  logic [OUT_CNT_W-1:0] valid_pixels;

  modport source (output valid, output save_frame, output became_reference,
                  output motion_found, output moved_pixels, output valid_pixels,
                  input ready);
  modport sink (input valid, input save_frame, input became_reference,
                input motion_found, input moved_pixels, input valid_pixels,
                output ready);
endinterface

// ===== sv/dfmd_regs.sv =====
// ----------------------------------------------------------------------------
// dfmd_regs
// APB register file holding the depth, rate and hold thresholds.
// ----------------------------------------------------------------------------
module dfmd_regs import dfmd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_threshold <= DEPTH_THR_RESET;
      cfg.rate_threshold  <= RATE_THR_RESET;
      cfg.hold_ticks      <= HOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEPTH_THR: cfg.depth_threshold <= pwdata[DEPTH_W-1:0];
        REG_RATE_THR:  cfg.rate_threshold  <= pwdata[RATE_W-1:0];
        REG_HOLD:      cfg.hold_ticks      <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEPTH_THR: prdata = PDATA_W'(cfg.depth_threshold);
      REG_RATE_THR:  prdata = PDATA_W'(cfg.rate_threshold);
      REG_HOLD:      prdata = PDATA_W'(cfg.hold_ticks);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== sv/dfmd_ref_mem.sv =====
// ----------------------------------------------------------------------------
// dfmd_ref_mem
// Single-port reference frame memory with a registered read.
// ----------------------------------------------------------------------------
module dfmd_ref_mem import dfmd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [DEPTH_W-1:0] wdata,
  output logic [DEPTH_W-1:0] rdata
);

  logic [DEPTH_W-1:0] mem [FRAME_PIXELS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/dfmd_stats.sv =====
// ----------------------------------------------------------------------------
// dfmd_stats
// Compares each depth pixel with its reference pixel and accumulates the valid
// and moved pixel counts of the current frame.
// ----------------------------------------------------------------------------
module dfmd_stats import dfmd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  pix_stage_t         s1,
  input  logic [DEPTH_W-1:0] ref_depth,
  input  logic [DEPTH_W-1:0] depth_threshold,
  output frame_stage_t       s3
);

  typedef struct packed {
    logic valid;
    logic tick;
    logic eof;
    logic is_ref;
    logic inc_v;
    logic inc_m;
  } flag_stage_t;

  flag_stage_t        s2;
  flag_stage_t        s2_next;
  logic [DEPTH_W-1:0] diff;
  logic               pix_ok;
  logic [CNT_W-1:0]   acc_v;
  logic [CNT_W-1:0]   acc_m;
  logic [CNT_W-1:0]   acc_v_next;
  logic [CNT_W-1:0]   acc_m_next;
  logic               s2_pix;

  always_comb begin
    pix_ok = s1.valid && !s1.tick && s1.cmp_en && (s1.depth != '0) && (ref_depth != '0);
    diff   = (s1.depth >= ref_depth) ? s1.depth - ref_depth : ref_depth - s1.depth;
    s2_next.valid  = s1.valid;
    s2_next.tick   = s1.tick;
    s2_next.eof    = s1.eof;
    s2_next.is_ref = s1.is_ref;
    s2_next.inc_v  = pix_ok;
    s2_next.inc_m  = pix_ok && (diff > depth_threshold);
  end

  assign s2_pix     = s2.valid && !s2.tick;
  assign acc_v_next = acc_v + CNT_W'(s2.inc_v);
  assign acc_m_next = acc_m + CNT_W'(s2.inc_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      acc_v    <= '0;
      acc_m    <= '0;
    end else if (adv) begin
      s2       <= s2_next;
      s3.valid  <= s2.valid;
      s3.tick   <= s2.tick;
      s3.eof    <= s2.eof;
      s3.is_ref <= s2.is_ref;
      s3.vcnt   <= acc_v_next;
      s3.mcnt   <= acc_m_next;
      if (s2_pix) begin
        if (s2.eof) begin
          acc_v <= '0;
          acc_m <= '0;
        end else begin
          acc_v <= acc_v_next;
          acc_m <= acc_m_next;
        end
      end
    end
  end

endmodule

// ===== sv/dfmd_decide.sv =====
// ----------------------------------------------------------------------------
// dfmd_decide
// Frame decision: rate test, hold counter and the output register.
// ----------------------------------------------------------------------------
module dfmd_decide import dfmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  frame_stage_t      s3,
  input  logic [RATE_W-1:0] rate_threshold,
  input  logic [HOLD_W-1:0] hold_ticks,
  output logic              adv,
  dfmd_out_if.source        result
);

  frame_stage_t        s4;
  logic [PROD_W-1:0]   prod;
  logic [HOLD_W-1:0]   quiet;
  logic                motion;
  logic                save;
  logic                is_result;
  logic                out_valid;
  logic                out_save;
  logic                out_ref;
  logic                out_motion;
  logic [OUT_CNT_W-1:0] out_moved;
  logic [OUT_CNT_W-1:0] out_valid_cnt;

  assign adv       = !out_valid || result.ready;
  assign is_result = s4.valid && !s4.tick && s4.eof;
  assign motion    = !s4.is_ref && ({s4.mcnt, {RATE_W{1'b0}}} > prod);
  assign save      = s4.is_ref || motion || (quiet < hold_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid  <= 1'b0;
      quiet     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s4        <= s3;
      prod      <= PROD_W'(rate_threshold) * PROD_W'(s3.vcnt);
      out_valid <= is_result;
      if (s4.valid && s4.tick) begin
        if (quiet != '1) begin
          quiet <= quiet + HOLD_W'(1);
        end
      end else if (is_result && motion) begin
        quiet <= '0;
      end
      if (is_result) begin
        out_save      <= save;
        out_ref       <= s4.is_ref;
        out_motion    <= motion;
        out_moved     <= s4.is_ref ? '0 : OUT_CNT_W'(s4.mcnt);
        out_valid_cnt <= s4.is_ref ? '0 : OUT_CNT_W'(s4.vcnt);
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.save_frame       = out_save;
  assign result.became_reference = out_ref;
  assign result.motion_found     = out_motion;
  assign result.moved_pixels     = out_moved;
  assign result.valid_pixels     = out_valid_cnt;

  a_ref_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ref) |-> (!out_motion && out_moved == '0 && out_valid_cnt == '0))
    else $error("reference result carries motion data");

  a_motion_saves: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_motion) |-> out_save)
    else $error("motion without save");

  a_moved_le_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ref) |-> (out_moved <= out_valid_cnt))
    else $error("moved count exceeds valid count");

  a_motion_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && is_result && motion) |=> (quiet == '0))
    else $error("hold counter not cleared by motion");

endmodule

// ===== sv/depth_frame_motion_detector.sv =====
// ----------------------------------------------------------------------------
// depth_frame_motion_detector
// Compares depth frames against a stored reference frame and decides, at the
// end of each frame, whether it shows motion and should be recorded.
// ----------------------------------------------------------------------------
// The sample channel takes one request per cycle while not stalled: a depth
// pixel (mode 0) or a timer tick (mode 1). The first frame after reset is
// written into the reference memory; every later pixel within the frame
// size reads its reference entry and is compared. Each pixel flagged as the
// end of a frame yields one request on the result channel; pixels and ticks
// otherwise yield nothing. Throughput is one sample per cycle while the
// result channel does not stall, set by the single reference memory port,
// which is read or written once per pixel. Each result passes the registers
// for memory read, compare, accumulate, multiply and decide, in that order.
// When the receiver stalls, the result waits in the output register and
// the whole pipeline holds, so the sample channel drops ready until the
// result is taken. Reset clears the pipeline, counters and the hold counter
// and returns the registers to their defaults; the reference memory is not
// cleared, the next frame simply overwrites it. Configuration is written
// through the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module depth_frame_motion_detector import dfmd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  dfmd_in_if.sink            sample,
  dfmd_out_if.source         result
);

  cfg_t               cfg;
  logic               adv;
  logic               accept;
  logic               pix;
  logic               in_range;
  logic               loaded;
  logic [IDX_W-1:0]   pixel_index;
  logic               mem_en;
  logic [DEPTH_W-1:0] ref_depth;
  pix_stage_t         s1;
  pix_stage_t         s1_next;
  frame_stage_t       s3;

  assign sample.ready = adv;
  assign accept       = sample.valid && adv;
  assign pix          = accept && !sample.mode;
  assign in_range     = pixel_index < IDX_W'(FRAME_PIXELS);
  assign mem_en       = pix && in_range;

  always_comb begin
    s1_next.valid  = accept;
    s1_next.tick   = sample.mode;
    s1_next.eof    = sample.end_of_frame;
    s1_next.is_ref = !loaded;
    s1_next.cmp_en = in_range && loaded;
    s1_next.depth  = sample.depth_mm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      loaded      <= 1'b0;
      s1.valid    <= 1'b0;
    end else begin
      if (adv) begin
        s1 <= s1_next;
      end
      if (pix) begin
        if (sample.end_of_frame) begin
          pixel_index <= '0;
          loaded      <= 1'b1;
        end else if (in_range) begin
          pixel_index <= pixel_index + IDX_W'(1);
        end
      end
    end
  end

  dfmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dfmd_ref_mem u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (!loaded),
    .addr  (pixel_index[ADDR_W-1:0]),
    .wdata (sample.depth_mm),
    .rdata (ref_depth)
  );

  dfmd_stats u_stats (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .s1              (s1),
    .ref_depth       (ref_depth),
    .depth_threshold (cfg.depth_threshold),
    .s3              (s3)
  );

  dfmd_decide u_decide (
    .clk            (clk),
    .rst            (rst),
    .s3             (s3),
    .rate_threshold (cfg.rate_threshold),
    .hold_ticks     (cfg.hold_ticks),
    .adv            (adv),
    .result         (result)
  );

endmodule

// ===== tb/depth_frame_motion_detector_tb.sv =====
// ----------------------------------------------------------------------------
// depth_frame_motion_detector_tb
// Self-checking bench for the depth frame motion detector. A short reference
// frame is streamed first, then directed frames, one frame of the reference
// length and randomized frames of pixels and timer ticks under nine register
// settings, at least 1660 requests in all. Every decision is predicted here and
// checked field by field in arrival order while both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module depth_frame_motion_detector_tb;
  import dfmd_pkg::*;

  localparam int REF_LEN = 128;

  typedef struct packed {
    logic                 save_frame;
    logic                 became_reference;
    logic                 motion_found;
    logic [OUT_CNT_W-1:0] moved_pixels;
    logic [OUT_CNT_W-1:0] valid_pixels;
  } decision_t;

  class decision_tracker;
    bit [DEPTH_W-1:0] ref_frame [FRAME_PIXELS];
    bit               ref_ready;
    int unsigned      px_pos;
    int unsigned      frame_valid;
    int unsigned      frame_moved;
    bit [HOLD_W-1:0]  quiet_count;
    bit [DEPTH_W-1:0] depth_thr;
    bit [RATE_W-1:0]  rate_thr;
    bit [HOLD_W-1:0]  hold_limit;
    decision_t        pending_decisions[$];
    int unsigned      errors;
    int unsigned      samples;
    int unsigned      ticks;
    int unsigned      decisions;
    int unsigned      motions;
    int unsigned      saves;

    function new();
      depth_thr  = DEPTH_THR_RESET;
      rate_thr   = RATE_THR_RESET;
      hold_limit = HOLD_RESET;
    endfunction

    function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_DEPTH_THR: depth_thr = value[DEPTH_W-1:0];
        REG_RATE_THR:  rate_thr = value[RATE_W-1:0];
        REG_HOLD:      hold_limit = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic tick, logic [DEPTH_W-1:0] depth, logic eof);
      int unsigned     stored;
      int unsigned     diff;
      longint unsigned lhs;
      longint unsigned rhs;
      bit              motion;
      decision_t       want;
      samples++;
      if (tick) begin
        ticks++;
        if (quiet_count != {HOLD_W{1'b1}}) quiet_count++;
        return;
      end
      if (px_pos < FRAME_PIXELS) begin
        if (!ref_ready) begin
          ref_frame[px_pos] = depth;
        end else begin
          stored = ref_frame[px_pos];
          if (depth != 0 && stored != 0) begin
            frame_valid++;
            diff = (depth > stored) ? depth - stored : stored - depth;
            if (diff > depth_thr) frame_moved++;
          end
        end
        px_pos++;
      end
      if (!eof) return;
      if (!ref_ready) begin
        ref_ready = 1'b1;
        want = '{1'b1, 1'b1, 1'b0, '0, '0};
      end else begin
        lhs = longint'(frame_moved) << 16;
        rhs = longint'(rate_thr) * longint'(frame_valid);
        motion = lhs > rhs;
        want.save_frame = motion || (quiet_count < hold_limit);
        want.became_reference = 1'b0;
        want.motion_found = motion;
        want.moved_pixels = OUT_CNT_W'(frame_moved);
        want.valid_pixels = OUT_CNT_W'(frame_valid);
        if (motion) quiet_count = '0;
      end
      pending_decisions.push_back(want);
      px_pos = 0;
      frame_valid = 0;
      frame_moved = 0;
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void compare_decision(decision_t got);
      decision_t want;
      decisions++;
      if (got.motion_found) motions++;
      if (got.save_frame) saves++;
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: decision expected none, got save=%0d ref=%0d motion=%0d moved=%0d valid=%0d",
                 $time, got.save_frame, got.became_reference, got.motion_found,
                 got.moved_pixels, got.valid_pixels);
        return;
      end
      want = pending_decisions.pop_front();
      check_field("save_frame", want.save_frame, got.save_frame);
      check_field("became_reference", want.became_reference, got.became_reference);
      check_field("motion_found", want.motion_found, got.motion_found);
      check_field("moved_pixels", want.moved_pixels, got.moved_pixels);
      check_field("valid_pixels", want.valid_pixels, got.valid_pixels);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dfmd_in_if  sample_ch ();
  dfmd_out_if result_ch ();

  depth_frame_motion_detector dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  decision_tracker tracker;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     stall_request;
  int unsigned     stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("depth_frame_motion_detector_tb: FAIL");
    $finish;
  end

  // The receiver serves a requested long stall before returning to random ready.
  initial begin
    result_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : watch
    decision_t got;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready)
        tracker.take_sample(sample_ch.mode, sample_ch.depth_mm, sample_ch.end_of_frame);
      if (result_ch.valid && result_ch.ready) begin
        got.save_frame = result_ch.save_frame;
        got.became_reference = result_ch.became_reference;
        got.motion_found = result_ch.motion_found;
        got.moved_pixels = result_ch.moved_pixels;
        got.valid_pixels = result_ch.valid_pixels;
        tracker.compare_decision(got);
      end
    end
  end

  task automatic push_sample(input logic tick, input logic [DEPTH_W-1:0] depth,
                             input logic eof);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.mode <= tick;
    sample_ch.depth_mm <= depth;
    sample_ch.end_of_frame <= eof;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic push_tick();
    push_sample(1'b1, DEPTH_W'($urandom_range(0, 65535)), 1'($urandom_range(1)));
  endtask

  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (tracker.pending_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  task automatic apply_settings(input logic [15:0] thr, input logic [15:0] rate,
                                input logic [31:0] hold);
    write_reg(REG_DEPTH_THR, {16'd0, thr});
    write_reg(REG_RATE_THR, {16'd0, rate});
    write_reg(REG_HOLD, hold);
  endtask

  // Depths cluster around the stored value at the threshold boundary.
  function automatic logic [DEPTH_W-1:0] pick_depth(int unsigned pos);
    int unsigned r;
    int unsigned base;
    int          cand;
    r = $urandom_range(99);
    if (pos >= FRAME_PIXELS) return DEPTH_W'($urandom_range(0, 65535));
    base = tracker.ref_frame[pos];
    if (r < 10) return '0;
    if (r < 20) return $urandom_range(1) ? 16'hFFFF : 16'd1;
    if (r < 35) return DEPTH_W'(base);
    if (r < 60 && base != 0) begin
      cand = int'(tracker.depth_thr) + int'($urandom_range(1));
      cand = $urandom_range(1) ? int'(base) + cand : int'(base) - cand;
      if (cand >= 1 && cand <= 65535) return DEPTH_W'(cand);
    end
    return DEPTH_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [DEPTH_W-1:0] ref_pixel(int unsigned pos);
    case (pos)
      0: return 16'd1000;
      1: return 16'd30000;
      2: return 16'd0;
      3: return 16'hFFFF;
      4: return 16'd1;
      default: return ($urandom_range(9) == 0) ? 16'd0 : DEPTH_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [15:0] thr;
    logic [15:0] rate;
    logic [31:0] hold;
    int unsigned sent;
    int unsigned len;
    tracker = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.mode = 1'b0;
    sample_ch.depth_mm = '0;
    sample_ch.end_of_frame = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The reference frame is short, and no later frame is longer than it.
    for (int i = 0; i < REF_LEN; i++)
      push_sample(1'b0, ref_pixel(i), i == REF_LEN - 1);
    settle();

    push_sample(1'b0, 16'd0, 1'b1);
    push_sample(1'b1, 16'hFFFF, 1'b1);
    push_sample(1'b0, 16'd1000, 1'b1);
    push_sample(1'b0, 16'd1200, 1'b0);
    push_sample(1'b0, 16'd30201, 1'b1);
    push_sample(1'b0, 16'hFFFF, 1'b0);
    push_sample(1'b0, 16'hFFFF, 1'b0);
    push_sample(1'b0, 16'hFFFF, 1'b0);
    push_sample(1'b0, 16'd1, 1'b0);
    push_sample(1'b0, 16'hFFFF, 1'b1);
    push_tick();
    for (int i = 0; i < REF_LEN; i++)
      push_sample(1'b0, pick_depth(i), i == REF_LEN - 1);
    settle();

    for (int p = 0; p < 9; p++) begin
      send_idle_pct = (p < 3) ? 30 : (p < 6) ? 71 : 0;
      recv_idle_pct = (p < 3) ? 71 : (p < 6) ? 30 : 0;
      thr = $urandom_range(1) ? 16'($urandom_range(0, 400)) : 16'($urandom_range(0, 65535));
      rate = 16'($urandom_range(0, 65535));
      hold = $urandom_range(1) ? 32'($urandom_range(0, 60)) : $urandom;
      case (p)
        0: apply_settings(16'd0, 16'd0, 32'd0);
        1: apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        2: apply_settings(16'd200, 16'd32768, 32'd20);
        4: apply_settings(16'($urandom_range(0, 300)), 16'hFFFF, 32'd0);
        6: apply_settings(16'hFFFF, 16'd0, 32'd5);
        8: apply_settings(16'd0, 16'hFFFF, 32'd8);
        default: apply_settings(thr, rate, hold);
      endcase
      if (p == 6) stall_request = 400;
      sent = 0;
      while (sent < 155) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 12) begin
            push_tick();
            sent++;
          end
          push_sample(1'b0, pick_depth(k), k == len - 1);
          sent++;
        end
      end
      settle();
    end

    $display("Run covered %0d requests, %0d of them timer ticks, and %0d frame decisions.",
             tracker.samples, tracker.ticks, tracker.decisions);
    $display("Motion was found in %0d decisions and %0d frames were marked for saving.",
             tracker.motions, tracker.saves);
    if (tracker.errors == 0 && tracker.pending_decisions.size() == 0) begin
      $display("depth_frame_motion_detector_tb: PASS");
    end else begin
      $display("depth_frame_motion_detector_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dfmd_pkg.sv
sv/dfmd_if.sv
sv/dfmd_regs.sv
sv/dfmd_ref_mem.sv
sv/dfmd_stats.sv
sv/dfmd_decide.sv
sv/depth_frame_motion_detector.sv
tb/depth_frame_motion_detector_tb.sv
